/* src/lmrs_pkg.sv */
package lmrs_pkg;

  // Frame geometry
  localparam int COLUMNS = 24;
  localparam int ROWS    = 8;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int BIT_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int WORD_W = 24;
  localparam int DWELL_W = 10;

  localparam logic [DWELL_W-1:0] DWELL_RESET = 10'd800;

  // Configuration register map (byte address bit 2 selects the register)
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_DWELL = 1'b0;

  // Input word kinds carried on tuser
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Pin levels, data pin in bit 0
  typedef struct packed {
    logic rst;
    logic adv;
    logic latch;
    logic clk;
    logic data;
  } pins_t;

endpackage

/* src/lmrs_seq.sv */
module lmrs_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           tick,
  input  logic [lmrs_pkg::WORD_W-1:0]    row_word,
  input  logic [lmrs_pkg::DWELL_W-1:0]   dwell_ticks,
  output logic [lmrs_pkg::ROW_W-1:0]     row,
  output lmrs_pkg::pins_t                pins_nxt
);
  import lmrs_pkg::*;

  typedef enum logic [2:0] {
    PH_SHIFT,
    PH_LATCH,
    PH_DWELL,
    PH_BLANK,
    PH_BLATCH,
    PH_LOW,
    PH_PULSE
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [BIT_W-1:0]     bit_pos_r, bit_pos_nxt;
  logic                 half_r, half_nxt;
  logic [DWELL_W-1:0]   cnt_r, cnt_nxt;
  logic [DWELL_W-1:0]   cnt_inc;
  pins_t                pins_r;
  logic [31:0]          word_ext;
  logic                 last_row;

  assign word_ext = (phase_r == PH_SHIFT) ? {{(32-WORD_W){1'b0}}, row_word} : 32'd0;
  assign last_row = (row_r == ROW_W'(ROWS - 1));
  assign cnt_inc  = cnt_r + DWELL_W'(1);

  always_comb begin
    phase_nxt   = phase_r;
    row_nxt     = row_r;
    bit_pos_nxt = bit_pos_r;
    half_nxt    = half_r;
    cnt_nxt     = cnt_r;
    pins_nxt    = pins_r;
    case (phase_r)
      PH_SHIFT, PH_BLANK: begin
        pins_nxt.data = word_ext[bit_pos_r];
        if (!half_r) begin
          pins_nxt.clk = 1'b0;
          half_nxt     = 1'b1;
        end else begin
          pins_nxt.clk = 1'b1;
          half_nxt     = 1'b0;
          if (bit_pos_r >= BIT_W'(COLUMNS - 1)) begin
            bit_pos_nxt = '0;
            phase_nxt   = (phase_r == PH_SHIFT) ? PH_LATCH : PH_BLATCH;
          end else begin
            bit_pos_nxt = bit_pos_r + BIT_W'(1);
          end
        end
      end
      PH_LATCH, PH_BLATCH: begin
        if (!half_r) begin
          pins_nxt.latch = 1'b0;
          half_nxt       = 1'b1;
        end else begin
          pins_nxt.latch = 1'b1;
          half_nxt       = 1'b0;
          if (phase_r == PH_LATCH) begin
            phase_nxt = PH_DWELL;
            cnt_nxt   = '0;
          end else begin
            phase_nxt = PH_LOW;
          end
        end
      end
      PH_DWELL: begin
        cnt_nxt = cnt_inc;
        // a zero setting ends the hold at once, since every count meets it
        if (cnt_inc >= dwell_ticks || cnt_inc == '0) begin
          cnt_nxt   = '0;
          phase_nxt = PH_BLANK;
        end
      end
      PH_LOW: begin
        pins_nxt  = '0;
        half_nxt  = 1'b0;
        phase_nxt = PH_PULSE;
      end
      PH_PULSE: begin
        if (!half_r) begin
          if (last_row) pins_nxt.rst = 1'b1;
          else          pins_nxt.adv = 1'b0;
          half_nxt = 1'b1;
        end else begin
          if (last_row) pins_nxt.rst = 1'b0;
          else          pins_nxt.adv = 1'b1;
          half_nxt    = 1'b0;
          bit_pos_nxt = '0;
          phase_nxt   = PH_SHIFT;
          row_nxt     = last_row ? '0 : row_r + ROW_W'(1);
        end
      end
      default: begin
        phase_nxt = PH_SHIFT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SHIFT;
      row_r     <= '0;
      bit_pos_r <= '0;
      half_r    <= 1'b0;
      cnt_r     <= '0;
      pins_r    <= '0;
    end else if (tick) begin
      phase_r   <= phase_nxt;
      row_r     <= row_nxt;
      bit_pos_r <= bit_pos_nxt;
      half_r    <= half_nxt;
      cnt_r     <= cnt_nxt;
      pins_r    <= pins_nxt;
    end
  end

  assign row = row_r;

endmodule

/* src/led_matrix_row_scanner.sv */
// Channel | Direction | Payload
// in_     | slave     | tdata = row_index, row_bits; tuser = func (0 tick, 1 row write)
// out_    | master    | tdata = pin levels and active_row, one word per tick
// cfg_    | APB slave | dwell_ticks at byte address 0
//
// One input word per cycle while in_tready is high; each word is applied in
// the cycle it is accepted, and a tick's pin levels land in the output
// register on the next edge. The output register parts the two sides;
// in_tready drops only while a result waits and out_tready is low.
// Synchronous active-low reset clears the frame buffer, the scan state and
// the pins, and loads dwell_ticks with 800.
module led_matrix_row_scanner (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [2:0] row_index, [26:3] row_bits, [31:27] zero
  input  logic        in_tuser,   // [0] func
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] serial_data, [1] shift_clock, [2] latch_out,
                                  // [3] row_advance, [4] row_reset, [7:5] active_row
  // configuration
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lmrs_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import lmrs_pkg::*;

  logic [WORD_W-1:0]  frame_r [ROWS];
  logic [DWELL_W-1:0] dwell_r;
  logic               out_valid_r;
  pins_t              out_pins_r;
  logic [2:0]         out_row_r;

  logic               in_acc;
  logic               tick;
  logic               wr_row;
  logic [2:0]         in_row_index;
  logic [WORD_W-1:0]  in_row_bits;
  logic [ROW_W-1:0]   scan_row;
  pins_t              pins_nxt;

  assign in_row_index = in_tdata[2:0];
  assign in_row_bits  = in_tdata[26:3];

  // Accept while the result slot is empty or being drained this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign tick      = in_acc && (in_tuser == FUNC_TICK);
  // Drop writes to rows beyond the frame
  assign wr_row    = in_acc && (in_tuser == FUNC_WRITE) && (int'(in_row_index) < ROWS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) frame_r[i] <= '0;
    end else if (wr_row) begin
      frame_r[ROW_W'(in_row_index)] <= in_row_bits;
    end
  end

  // APB: always ready, write on the access phase
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_r <= DWELL_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_DWELL) begin
      dwell_r <= cfg_pwdata[DWELL_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_DWELL) ? {{(32-DWELL_W){1'b0}}, dwell_r} : 32'd0;

  lmrs_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (tick),
    .row_word    (frame_r[scan_row]),
    .dwell_ticks (dwell_r),
    .row         (scan_row),
    .pins_nxt    (pins_nxt)
  );

  // Result register: pins after the step, row shown before it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      out_pins_r <= pins_nxt;
      out_row_r  <= 3'(scan_row);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_row_r, out_pins_r};

`ifndef SYNTHESIS
  // A tick always leaves a result behind
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> out_valid_r)
    else $error("tick produced no result");

  // A row write into an empty slot creates no result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == FUNC_WRITE && !out_valid_r) |=> !out_valid_r)
    else $error("row write produced a result");

  // Row reset and row advance are never high together
  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_pins_r.adv && out_pins_r.rst))
    else $error("row advance and row reset both high");
`endif

endmodule
